@@ hdl/owm_pkg.sv @@
package owm_pkg;

    // Codes carried in the input tuser field.
    typedef enum logic [1:0] {
        OP_START_RESET = 2'd0,
        OP_START_READ  = 2'd1,
        OP_START_WRITE = 2'd2,
        OP_BYTE_DONE   = 2'd3
    } t_opcode;

    // Phase of the operation in progress.
    typedef enum logic [1:0] {
        KIND_RESET_LOW = 2'd0,
        KIND_READ      = 2'd1,
        KIND_WRITE     = 2'd2,
        KIND_PRESENCE  = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic CFG_RESET_LOW_BYTES  = 1'b0;
    localparam logic CFG_PRESENCE_WINDOWS = 1'b1;

    localparam logic [3:0] RESET_LOW_BYTES_INIT  = 4'd8;
    localparam logic [2:0] PRESENCE_WINDOWS_INIT = 3'd4;

    // SPI byte patterns that form bus slots.
    localparam logic [7:0] SLOT_LOW      = 8'h00;
    localparam logic [7:0] SLOT_ONE      = 8'h7F;
    localparam logic [7:0] SLOT_RELEASE  = 8'hFF;
    localparam logic [5:0] READ_ONE_MASK = 6'h3F;
    localparam logic [2:0] PRESENCE_MAX  = 3'd7;
    localparam logic [3:0] LAST_BIT_SLOT = 4'd7;

    typedef struct packed {
        logic       busy;
        t_kind      kind;
        logic [3:0] slot_index;
        logic [7:0] shift_data;
        logic [2:0] presence_count;
    } t_state;

    typedef struct packed {
        logic       rejected;
        logic [7:0] answer;
        logic       done_res;
        logic [7:0] send_byte;
        logic       send_valid;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ hdl/owm_step.sv @@
module owm_step (
    input  owm_pkg::t_state  i_state,
    input  owm_pkg::t_opcode i_opcode,
    input  logic [7:0]       i_write_byte,
    input  logic [7:0]       i_received_byte,
    input  logic [3:0]       i_reset_low_bytes,
    input  logic [2:0]       i_presence_windows,
    output owm_pkg::t_state  o_state,
    output owm_pkg::t_result o_result
);

    logic [4:0] w_done_slots;
    logic [7:0] w_read_shift;
    logic [7:0] w_write_shift;
    logic [2:0] w_presence;

    assign w_done_slots  = {1'b0, i_state.slot_index} + 5'd1;
    assign w_read_shift  = {(i_received_byte[5:0] == owm_pkg::READ_ONE_MASK),
                            i_state.shift_data[7:1]};
    assign w_write_shift = {1'b0, i_state.shift_data[7:1]};
    assign w_presence    = ((i_received_byte == 8'h00) &&
                            (i_state.presence_count != owm_pkg::PRESENCE_MAX)) ?
                           i_state.presence_count + 3'd1 : i_state.presence_count;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_opcode != owm_pkg::OP_BYTE_DONE) begin
            if (i_state.busy) begin
                o_result.rejected = 1'b1;
            end else begin
                o_state.busy       = 1'b1;
                o_state.slot_index = 4'd0;
                o_result.send_valid = 1'b1;
                unique case (i_opcode)
                    owm_pkg::OP_START_RESET: begin
                        o_state.kind           = owm_pkg::KIND_RESET_LOW;
                        o_state.presence_count = 3'd0;
                        o_result.send_byte     = owm_pkg::SLOT_LOW;
                    end
                    owm_pkg::OP_START_READ: begin
                        o_state.kind       = owm_pkg::KIND_READ;
                        o_state.shift_data = 8'h00;
                        o_result.send_byte = owm_pkg::SLOT_ONE;
                    end
                    default: begin
                        o_state.kind       = owm_pkg::KIND_WRITE;
                        o_state.shift_data = i_write_byte;
                        o_result.send_byte = i_write_byte[0] ? owm_pkg::SLOT_ONE :
                                                               owm_pkg::SLOT_LOW;
                    end
                endcase
            end
        end else if (!i_state.busy) begin
            o_result.rejected = 1'b1;
        end else begin
            unique case (i_state.kind)
                owm_pkg::KIND_RESET_LOW: begin
                    o_result.send_valid = 1'b1;
                    if (w_done_slots >= {1'b0, i_reset_low_bytes}) begin
                        o_state.kind       = owm_pkg::KIND_PRESENCE;
                        o_state.slot_index = 4'd0;
                        o_result.send_byte = owm_pkg::SLOT_RELEASE;
                    end else begin
                        o_state.slot_index = w_done_slots[3:0];
                        o_result.send_byte = owm_pkg::SLOT_LOW;
                    end
                end
                owm_pkg::KIND_PRESENCE: begin
                    o_state.presence_count = w_presence;
                    if (w_done_slots >= {2'b00, i_presence_windows}) begin
                        o_state.busy       = 1'b0;
                        o_state.slot_index = 4'd0;
                        o_result.done_res  = 1'b1;
                        o_result.answer    = {5'd0, w_presence};
                    end else begin
                        o_state.slot_index  = w_done_slots[3:0];
                        o_result.send_valid = 1'b1;
                        o_result.send_byte  = owm_pkg::SLOT_RELEASE;
                    end
                end
                owm_pkg::KIND_READ: begin
                    o_state.shift_data = w_read_shift;
                    if (i_state.slot_index >= owm_pkg::LAST_BIT_SLOT) begin
                        o_state.busy       = 1'b0;
                        o_state.slot_index = 4'd0;
                        o_result.done_res  = 1'b1;
                        o_result.answer    = w_read_shift;
                    end else begin
                        o_state.slot_index  = w_done_slots[3:0];
                        o_result.send_valid = 1'b1;
                        o_result.send_byte  = owm_pkg::SLOT_ONE;
                    end
                end
                default: begin
                    o_state.shift_data = w_write_shift;
                    if (i_state.slot_index >= owm_pkg::LAST_BIT_SLOT) begin
                        o_state.busy       = 1'b0;
                        o_state.slot_index = 4'd0;
                        o_result.done_res  = 1'b1;
                    end else begin
                        o_state.slot_index  = w_done_slots[3:0];
                        o_result.send_valid = 1'b1;
                        o_result.send_byte  = w_write_shift[0] ? owm_pkg::SLOT_ONE :
                                                                 owm_pkg::SLOT_LOW;
                    end
                end
            endcase
        end
    end

endmodule

@@ hdl/owm_out_reg.sv @@
module owm_out_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  owm_pkg::t_result               i_result,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic [owm_pkg::M_TDATA_W-1:0]  o_data
);

    logic             r_valid;
    logic             n_valid;
    owm_pkg::t_result r_result;

    // Load wins over a take in the same cycle: the old word leaves as the new one enters.
    assign n_valid = i_load | (r_valid & ~i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{(owm_pkg::M_TDATA_W - owm_pkg::RESULT_W){1'b0}}, r_result};

endmodule

@@ hdl/one_wire_master_over_spi_bytes_core.sv @@
// 1-Wire bus master that forms every bus slot from one whole SPI byte.
//
// Input channel (s_*): each word is either a start command (reset, read or
// write, with the byte to write) or a report that the SPI engine has finished
// a byte, carrying the byte it shifted in. Output channel (m_*): exactly one
// word per input word, giving the next byte to send on SPI, completion with
// the answer (read byte or count of zero presence windows), or a rejection
// flag for a start while busy or a byte report while idle.
//
// The result of an accepted word is registered and valid on the output in
// the cycle after it is accepted. Throughput is one word per cycle; the only
// limit is the single output register, which the next word may refill in
// the same cycle that the waiting word is taken.
//
// When the receiver stalls, the output register holds its word and s_tready
// falls until that word has been taken. Reset (synchronous, active low)
// leaves the block idle with an empty output register and the configuration
// at eight reset-low bytes and four presence windows. Configuration is written
// via a simple write-enable port, by the user only while idle; not enforced.
module one_wire_master_over_spi_bytes_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // write_byte [7:0], received_byte [15:8]
    input  logic [1:0]  i_s_tuser,   // opcode [1:0]
    // Result words.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [owm_pkg::M_TDATA_W-1:0] o_m_tdata,
    // send_valid [0], send_byte [8:1], done_res [9], answer [17:10],
    // rejected [18], zero padding above
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    owm_pkg::t_state  r_state;
    owm_pkg::t_state  n_state;
    owm_pkg::t_result w_result;
    logic [3:0]       r_reset_low_bytes;
    logic [2:0]       r_presence_windows;
    logic             w_accept;

    // The block takes a new word whenever the output register is empty or is
    // being emptied in this same cycle.
    assign o_s_tready = ~o_m_tvalid | i_m_tready;
    assign w_accept   = i_s_tvalid & o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low_bytes  <= owm_pkg::RESET_LOW_BYTES_INIT;
            r_presence_windows <= owm_pkg::PRESENCE_WINDOWS_INIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                owm_pkg::CFG_RESET_LOW_BYTES:  r_reset_low_bytes  <= i_cfg_data;
                owm_pkg::CFG_PRESENCE_WINDOWS: r_presence_windows <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Sequencing state moves only on an accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    owm_step u_step (
        .i_state           (r_state),
        .i_opcode          (owm_pkg::t_opcode'(i_s_tuser)),
        .i_write_byte      (i_s_tdata[7:0]),
        .i_received_byte   (i_s_tdata[15:8]),
        .i_reset_low_bytes (r_reset_low_bytes),
        .i_presence_windows(r_presence_windows),
        .o_state           (n_state),
        .o_result          (w_result)
    );

    owm_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_result(w_result),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata)
    );

`ifndef NO_ASSERTIONS
    // Input is held back only while a finished word waits at the output.
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without a waiting result");

    // A completion result always returns the block to idle.
    a_done_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_result.done_res) |=> !r_state.busy)
        else $error("busy still set after completion");

    // A rejected word leaves the sequencing state untouched.
    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_result.rejected) |=> $stable(r_state))
        else $error("rejected word changed state");

    // Read and write phases never pass their eighth slot.
    a_bit_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.busy && (r_state.kind == owm_pkg::KIND_READ ||
                          r_state.kind == owm_pkg::KIND_WRITE))
        |-> (r_state.slot_index <= owm_pkg::LAST_BIT_SLOT))
        else $error("bit slot index out of range");

    // A result word never both asks for a byte and reports completion.
    a_send_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !(w_result.send_valid && w_result.done_res))
        else $error("send and done in one result");
`endif

endmodule

@@ tb/one_wire_master_over_spi_bytes_core_tb.sv @@
`timescale 1ns / 1ps

// Scoreboard for the 1-Wire slot sequencer. It keeps its own copy of the
// sequencer state and configuration, works out the reply to every accepted
// input word and checks replies against them in order.
module one_wire_master_over_spi_bytes_core_tb;

    class slot_byte_scoreboard;
        // Configuration as the block should currently hold it.
        logic [3:0]       low_bytes;
        logic [2:0]       windows;
        // Sequencer state.
        logic             busy;
        owm_pkg::t_kind   kind;
        logic [3:0]       slot;
        logic [7:0]       shift;
        logic [2:0]       zero_windows;
        // Replies still owed by the block, oldest first.
        owm_pkg::t_result due_replies[$];
        int               errors;

        function new();
            low_bytes    = owm_pkg::RESET_LOW_BYTES_INIT;
            windows      = owm_pkg::PRESENCE_WINDOWS_INIT;
            busy         = 1'b0;
            kind         = owm_pkg::KIND_RESET_LOW;
            slot         = '0;
            shift        = '0;
            zero_windows = '0;
            errors       = 0;
        endfunction

        function void set_register(logic index, logic [3:0] value);
            if (index == owm_pkg::CFG_RESET_LOW_BYTES) begin
                low_bytes = value;
            end else begin
                windows = value[2:0];
            end
        endfunction

        function int pending();
            return due_replies.size();
        endfunction

        // Advances the sequencer by one input word and returns its reply.
        function owm_pkg::t_result next_slot_reply(owm_pkg::t_opcode op, logic [7:0] wb,
                                                   logic [7:0] rx);
            owm_pkg::t_result r;
            logic [4:0]       done_slots;
            r = '0;
            if (op != owm_pkg::OP_BYTE_DONE) begin
                // A start is only taken while idle.
                if (busy) begin
                    r.rejected = 1'b1;
                    return r;
                end
                busy         = 1'b1;
                slot         = '0;
                r.send_valid = 1'b1;
                case (op)
                    owm_pkg::OP_START_RESET: begin
                        kind         = owm_pkg::KIND_RESET_LOW;
                        zero_windows = '0;
                        r.send_byte  = owm_pkg::SLOT_LOW;
                    end
                    owm_pkg::OP_START_READ: begin
                        kind        = owm_pkg::KIND_READ;
                        shift       = '0;
                        r.send_byte = owm_pkg::SLOT_ONE;
                    end
                    default: begin
                        kind        = owm_pkg::KIND_WRITE;
                        shift       = wb;
                        r.send_byte = wb[0] ? owm_pkg::SLOT_ONE : owm_pkg::SLOT_LOW;
                    end
                endcase
                return r;
            end
            if (!busy) begin
                r.rejected = 1'b1;
                return r;
            end
            done_slots = {1'b0, slot} + 5'd1;
            case (kind)
                owm_pkg::KIND_RESET_LOW: begin
                    // A count of zero behaves as one, since the first byte has
                    // already gone out with the start.
                    r.send_valid = 1'b1;
                    if (done_slots >= {1'b0, low_bytes}) begin
                        kind        = owm_pkg::KIND_PRESENCE;
                        slot        = '0;
                        r.send_byte = owm_pkg::SLOT_RELEASE;
                    end else begin
                        slot        = done_slots[3:0];
                        r.send_byte = owm_pkg::SLOT_LOW;
                    end
                end
                owm_pkg::KIND_PRESENCE: begin
                    if (rx == 8'h00 && zero_windows < owm_pkg::PRESENCE_MAX) begin
                        zero_windows = zero_windows + 3'd1;
                    end
                    if (done_slots >= {2'b00, windows}) begin
                        busy       = 1'b0;
                        slot       = '0;
                        r.done_res = 1'b1;
                        r.answer   = {5'd0, zero_windows};
                    end else begin
                        slot         = done_slots[3:0];
                        r.send_valid = 1'b1;
                        r.send_byte  = owm_pkg::SLOT_RELEASE;
                    end
                end
                owm_pkg::KIND_READ: begin
                    // Bits come in least significant first.
                    shift = {(rx[5:0] == owm_pkg::READ_ONE_MASK), shift[7:1]};
                    if (slot >= owm_pkg::LAST_BIT_SLOT) begin
                        busy       = 1'b0;
                        slot       = '0;
                        r.done_res = 1'b1;
                        r.answer   = shift;
                    end else begin
                        slot         = slot + 4'd1;
                        r.send_valid = 1'b1;
                        r.send_byte  = owm_pkg::SLOT_ONE;
                    end
                end
                default: begin
                    shift = shift >> 1;
                    if (slot >= owm_pkg::LAST_BIT_SLOT) begin
                        busy       = 1'b0;
                        slot       = '0;
                        r.done_res = 1'b1;
                    end else begin
                        slot         = slot + 4'd1;
                        r.send_valid = 1'b1;
                        r.send_byte  = shift[0] ? owm_pkg::SLOT_ONE : owm_pkg::SLOT_LOW;
                    end
                end
            endcase
            return r;
        endfunction

        function void note_word(owm_pkg::t_opcode op, logic [7:0] wb, logic [7:0] rx);
            due_replies.push_back(next_slot_reply(op, wb, rx));
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ns mismatch: %s", $time, msg);
        endtask

        task check_reply(owm_pkg::t_result got);
            owm_pkg::t_result want;
            if (due_replies.size() == 0) begin
                report("reply word arrived with none due");
                return;
            end
            want = due_replies.pop_front();
            if (got.send_valid !== want.send_valid)
                report($sformatf("send_valid %b, want %b", got.send_valid, want.send_valid));
            if (got.send_byte !== want.send_byte)
                report($sformatf("send_byte %h, want %h", got.send_byte, want.send_byte));
            if (got.done_res !== want.done_res)
                report($sformatf("done_res %b, want %b", got.done_res, want.done_res));
            if (got.answer !== want.answer)
                report($sformatf("answer %h, want %h", got.answer, want.answer));
            if (got.rejected !== want.rejected)
                report($sformatf("rejected %b, want %b", got.rejected, want.rejected));
        endtask
    endclass

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_WORDS  = 172;
    localparam int HOLD_CYCLES  = 300;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [15:0]                   i_s_tdata = '0;
    logic [1:0]                    i_s_tuser = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [owm_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_index = 1'b0;
    logic [3:0]                    i_cfg_data = '0;

    slot_byte_scoreboard sb;
    int  cycle_count = 0;
    // Idling switches for each side, and a request for one long receiver stall.
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  hold_request = 1'b0;

    one_wire_master_over_spi_bytes_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake must not leave the run going for ever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("one_wire_master_over_spi_bytes_core_tb: errors");
            $finish;
        end
    end

    // Both channels are watched at the rising edge. The input word is noted
    // before the reply is checked: with a registered output, a reply taken at
    // this edge always belongs to a word accepted at an earlier one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_word(owm_pkg::t_opcode'(i_s_tuser), i_s_tdata[7:0],
                             i_s_tdata[15:8]);
            if (o_m_tvalid && i_m_tready)
                sb.check_reply(owm_pkg::t_result'(o_m_tdata[owm_pkg::RESULT_W-1:0]));
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver side. It stalls at random while idling is on, and when asked
    // holds off for a long stretch so that the output register fills and the
    // block has to stall its input.
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() - 1;
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // Offers one word, entered and left at a falling edge. tvalid stays high
    // when the next word follows without a gap.
    task automatic push_word(owm_pkg::t_opcode op, logic [7:0] wb, logic [7:0] rx);
        if (tx_idle_on && $urandom_range(0, 9) < 3) begin
            i_s_tvalid = 1'b0;
            repeat (pick_gap()) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = {rx, wb};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Sender pause: nothing is offered until every reply has been taken.
    task automatic drain_replies();
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_register(logic index, logic [3:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        sb.set_register(index, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One random word. Most follow the protocol (a start when idle, a byte
    // report while busy) with random content; about one in ten is noise.
    task automatic random_word();
        owm_pkg::t_opcode op;
        logic [7:0]       wb;
        logic [7:0]       rx;
        wb = 8'($urandom);
        rx = 8'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            op = owm_pkg::t_opcode'($urandom_range(0, 3));
        end else if (sb.busy) begin
            op = owm_pkg::OP_BYTE_DONE;
        end else begin
            case ($urandom_range(0, 2))
                0:       op = owm_pkg::OP_START_RESET;
                1:       op = owm_pkg::OP_START_READ;
                default: op = owm_pkg::OP_START_WRITE;
            endcase
        end
        // Bias the received bytes so that read ones and presence zeros are
        // common rather than rare.
        if (op == owm_pkg::OP_BYTE_DONE && sb.busy && $urandom_range(0, 1) == 1) begin
            if (sb.kind == owm_pkg::KIND_READ)
                rx[5:0] = owm_pkg::READ_ONE_MASK;
            else if (sb.kind == owm_pkg::KIND_PRESENCE)
                rx = 8'h00;
        end
        push_word(op, wb, rx);
    endtask

    initial begin
        logic [7:0] read_bytes [8];
        sb = new();
        read_bytes = '{8'h3F, 8'hC0, 8'hFF, 8'h00, 8'h7F, 8'hBF, 8'h3E, 8'hFF};

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed words: a byte report while idle, a write of all ones with
        // a start arriving mid-write, then a read over mixed slot patterns.
        push_word(owm_pkg::OP_BYTE_DONE, 8'h00, 8'hFF);
        push_word(owm_pkg::OP_START_WRITE, 8'hFF, 8'h00);
        for (int i = 0; i < 8; i++) begin
            if (i == 3)
                push_word(owm_pkg::OP_START_READ, 8'h00, 8'hFF);
            push_word(owm_pkg::OP_BYTE_DONE, 8'h00, 8'h00);
        end
        push_word(owm_pkg::OP_START_READ, 8'h00, 8'h00);
        for (int i = 0; i < 8; i++)
            push_word(owm_pkg::OP_BYTE_DONE, 8'hFF, read_bytes[i]);

        // Random phases: default settings, the extremes (zero acting as one),
        // then random settings. Each change is made once the block has no
        // reply outstanding, often with an operation still in flight.
        for (int phase = 0; phase < 7; phase++) begin
            drain_replies();
            case (phase)
                0: ;
                1: begin
                    write_register(owm_pkg::CFG_RESET_LOW_BYTES, 4'd1);
                    write_register(owm_pkg::CFG_PRESENCE_WINDOWS, 4'd1);
                end
                2: begin
                    write_register(owm_pkg::CFG_RESET_LOW_BYTES, 4'd15);
                    write_register(owm_pkg::CFG_PRESENCE_WINDOWS, 4'd7);
                end
                3: begin
                    write_register(owm_pkg::CFG_RESET_LOW_BYTES, 4'd0);
                    write_register(owm_pkg::CFG_PRESENCE_WINDOWS, 4'd0);
                end
                default: begin
                    write_register(owm_pkg::CFG_RESET_LOW_BYTES,
                                   4'($urandom_range(0, 15)));
                    write_register(owm_pkg::CFG_PRESENCE_WINDOWS,
                                   4'($urandom_range(0, 15)));
                end
            endcase
            // Alternate stretches with and without idling on each side.
            tx_idle_on = (phase % 3) != 2;
            rx_idle_on = (phase % 4) != 3;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (phase == 1 && n == 40)
                    hold_request = 1'b1;
                if (phase == 5 && n == 90)
                    drain_replies();
                random_word();
            end
        end

        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("one_wire_master_over_spi_bytes_core_tb: clean");
        end else begin
            $display("one_wire_master_over_spi_bytes_core_tb: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/owm_pkg.sv
hdl/owm_step.sv
hdl/owm_out_reg.sv
hdl/one_wire_master_over_spi_bytes_core.sv
tb/one_wire_master_over_spi_bytes_core_tb.sv
